@@ src/vps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package vps_pkg;

   // Fixed field widths of the request, result and register ports.
   localparam int SCORE_W   = 25;
   localparam int COORD_W   = 20;
   localparam int EXTENT_W  = 16;
   localparam int FRAC_W    = 4;
   localparam int TYPE_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int UPC_W     = 4;
   localparam int COND_W    = 3;

   // Request types.
   localparam logic [TYPE_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NOP    = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Jump conditions of the microcode.
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_START = 3'd2;
   localparam logic [COND_W-1:0] COND_IS_CLEAR = 3'd3;
   localparam logic [COND_W-1:0] COND_IS_NOP   = 3'd4;
   localparam logic [COND_W-1:0] COND_CNT_NZ   = 3'd5;
   localparam logic [COND_W-1:0] COND_CLR_MORE = 3'd6;

   // Microcode step addresses.
   localparam logic [UPC_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [UPC_W-1:0] STEP_DISPATCH  = 4'd1;
   localparam logic [UPC_W-1:0] STEP_DIV_INIT  = 4'd2;
   localparam logic [UPC_W-1:0] STEP_DIV_LOOP  = 4'd3;
   localparam logic [UPC_W-1:0] STEP_FIX       = 4'd4;
   localparam logic [UPC_W-1:0] STEP_RD_FIRST  = 4'd5;
   localparam logic [UPC_W-1:0] STEP_LVL_LOOP  = 4'd6;
   localparam logic [UPC_W-1:0] STEP_DONE      = 4'd7;
   localparam logic [UPC_W-1:0] STEP_CLR_INIT  = 4'd8;
   localparam logic [UPC_W-1:0] STEP_CLR_LOOP  = 4'd9;
   localparam logic [UPC_W-1:0] STEP_CLR_END   = 4'd10;
   localparam logic [UPC_W-1:0] STEP_RST_INIT  = 4'd11;
   localparam logic [UPC_W-1:0] STEP_RST_LOOP  = 4'd12;
   localparam logic [UPC_W-1:0] STEP_RST_END   = 4'd13;

   // One control word of the program.
   typedef struct packed {
      logic [COND_W-1:0] cond;
      logic [UPC_W-1:0]  target;
      logic              div_init;
      logic              div_step;
      logic              fix;
      logic              rd_first;
      logic              lvl_step;
      logic              emit;
      logic              clr_init;
      logic              clr_step;
   } ctl_word_type;

   // Datapath conditions the sequencer branches on.
   typedef struct packed {
      logic start;
      logic is_clear;
      logic is_nop;
      logic cnt_nz;
      logic clr_more;
   } seq_flags_type;

endpackage

`default_nettype wire

@@ src/visibility_pyramid_score.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Occupancy pyramid score engine.
//
// A request is taken at a rising edge where start is high and busy is low. It
// carries a request type (add point, remove point, clear all) and a point in
// signed 16.4 fixed-point pixels. Each request produces exactly one result:
// rsp_valid is high for one cycle with the current score and a status bit that
// flags a counter saturating at zero or at its maximum. The receiver cannot
// stall, so results are never held back.
// An add or remove request runs a short microprogram: LEVELS steps of a
// bit-serial divider map the point to its finest cell, then LEVELS
// read-modify-write steps update one counter per level through the one-read,
// one-write counter memory. busy drops at the same edge that raises the result
// strobe, and no new request is taken before the result of the last one. An
// unused request type goes from the divider set-up step straight to the done
// step. A clear request sweeps the whole counter memory one entry per cycle and
// gives its result when the sweep ends. After reset the same sweep runs with
// busy high and no result, and busy drops when it ends; width and height
// reset to 1. The csr_ port is always ready and should only be written while
// busy is low and no result is pending.

module visibility_pyramid_score
   import vps_pkg::*;
#(
   parameter int LEVELS     = 6,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [TYPE_W-1:0]           req_type,
   input  wire logic signed [COORD_W-1:0]   req_point_x,
   input  wire logic signed [COORD_W-1:0]   req_point_y,
   output logic                             rsp_valid,
   output logic [SCORE_W-1:0]               rsp_score,
   output logic                             rsp_status,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [EXTENT_W-1:0]         csr_wdata
);

   // Cells over all levels: 4 + 16 + ... + 4^LEVELS.
   localparam int CELL_TOTAL = ((1 << (2 * (LEVELS + 1))) - 4) / 3;
   localparam int ADDR_W     = $clog2(CELL_TOTAL);
   localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SH_W       = $clog2(2 * LEVELS + 1) + 1;

   ctl_word_type  ctl;
   seq_flags_type flags;
   logic          accept;

   // Request and configuration registers.
   logic [TYPE_W-1:0]   type_ff;
   logic [COORD_W-1:0]  x_ff;
   logic [COORD_W-1:0]  y_ff;
   logic [EXTENT_W-1:0] width_ff;
   logic [EXTENT_W-1:0] height_ff;

   // Divider remainders; the quotients build up in the cell registers.
   logic [COORD_W-1:0] rx_ff, rx_in;
   logic [COORD_W-1:0] ry_ff, ry_in;
   logic [LEVELS-1:0]  cx_ff, cx_in;
   logic [LEVELS-1:0]  cy_ff, cy_in;
   logic [LVL_W-1:0]   cnt_ff, cnt_in;

   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               status_ff, status_in;

   logic               rsp_valid_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic               rsp_status_ff;

   // Counter memory.
   logic [COUNT_BITS-1:0] cell_count_ff [CELL_TOTAL];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wa;
   logic [COUNT_BITS-1:0] mem_wd;

   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic [COORD_W:0]   divx;
   logic [COORD_W:0]   divy;

   logic [ADDR_W-1:0]     base_tab [LEVELS];
   logic [LVL_W-1:0]      lvl_next;
   logic [LVL_W-1:0]      lvl_sel;
   logic [LEVELS-1:0]     cx_sel;
   logic [LEVELS-1:0]     cy_sel;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SH_W-1:0]       cell_sh;
   logic [SCORE_W-1:0]    cells;
   logic [COUNT_BITS-1:0] upd_data;
   logic                  upd_sat;
   logic [SCORE_W-1:0]    upd_score;

   // One restoring division step: returns the quotient bit over the new remainder.
   function automatic logic [COORD_W:0] div_next(logic [COORD_W-1:0] rem,
                                                 logic [COORD_W-1:0] d);
      logic [COORD_W:0] t;
      t = {rem, 1'b0};
      if (t >= {1'b0, d}) begin
         div_next = {1'b1, COORD_W'(t - {1'b0, d})};
      end else begin
         div_next = {1'b0, t[COORD_W-1:0]};
      end
   endfunction

   // Negative points land in cell 0; a point at or beyond the extent lands
   // in the last cell, which also covers a zero extent.
   function automatic logic [LEVELS-1:0] fine_cell(logic [COORD_W-1:0] raw,
                                                   logic [COORD_W-1:0] d,
                                                   logic [LEVELS-1:0]  q);
      if (raw[COORD_W-1]) begin
         fine_cell = '0;
      end else if (raw >= d) begin
         fine_cell = '1;
      end else begin
         fine_cell = q;
      end
   endfunction

   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign flags.start    = start;
   assign flags.is_clear = (type_ff == REQ_CLEAR);
   assign flags.is_nop   = (type_ff == REQ_NOP);
   assign flags.cnt_nz   = (cnt_ff != '0);
   assign flags.clr_more = (clr_addr_ff != ADDR_W'(CELL_TOTAL - 1));

   vps_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy)
   );

   // Divisors are the extents scaled to 16.4 units.
   assign dx   = {width_ff, {FRAC_W{1'b0}}};
   assign dy   = {height_ff, {FRAC_W{1'b0}}};
   assign divx = div_next(rx_ff, dx);
   assign divy = div_next(ry_ff, dy);

   // First cell of each level in the flat counter memory.
   always_comb begin
      base_tab[0] = '0;
      for (int i = 1; i < LEVELS; i++) begin
         base_tab[i] = base_tab[i-1] + (ADDR_W'(1) << (2 * i));
      end
   end

   // Read address: the starting level on the first read, otherwise the
   // level below the one being written back, with the indexes halved.
   always_comb begin
      lvl_next = flags.cnt_nz ? cnt_ff - LVL_W'(1) : '0;
      lvl_sel  = ctl.rd_first ? cnt_ff : lvl_next;
      cx_sel   = ctl.rd_first ? cx_ff : cx_ff >> 1;
      cy_sel   = ctl.rd_first ? cy_ff : cy_ff >> 1;
      rd_addr  = base_tab[lvl_sel]
               + (ADDR_W'(cy_sel) << (SH_W'(lvl_sel) + SH_W'(1)))
               + ADDR_W'(cx_sel);
   end

   // Counter update of the level held in cnt_ff; its cell count is 4^(level+1).
   always_comb begin
      cell_sh   = (SH_W'(cnt_ff) + SH_W'(1)) << 1;
      cells     = SCORE_W'(1) << cell_sh;
      upd_data  = rd_data_ff;
      upd_sat   = 1'b0;
      upd_score = score_ff;
      if (type_ff == REQ_ADD) begin
         if (rd_data_ff == '1) begin
            upd_sat = 1'b1;
         end else begin
            upd_data = rd_data_ff + COUNT_BITS'(1);
            if (rd_data_ff == '0) begin
               upd_score = score_ff + cells;
            end
         end
      end else begin
         if (rd_data_ff == '0) begin
            upd_sat = 1'b1;
         end else begin
            upd_data = rd_data_ff - COUNT_BITS'(1);
            if (rd_data_ff == COUNT_BITS'(1)) begin
               upd_score = score_ff - cells;
            end
         end
      end
   end

   // Memory write port: the clearing sweep or the write-back of a level.
   assign mem_we = ctl.lvl_step || ctl.clr_step;
   assign mem_wa = ctl.clr_step ? clr_addr_ff : addr_ff;
   assign mem_wd = ctl.clr_step ? '0 : upd_data;

   // Next values of the datapath registers.
   always_comb begin
      rx_in       = rx_ff;
      ry_in       = ry_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      cnt_in      = cnt_ff;
      clr_addr_in = clr_addr_ff;
      score_in    = score_ff;
      status_in   = status_ff;

      if (accept) begin
         status_in = 1'b0;
      end
      if (ctl.div_init) begin
         rx_in  = {1'b0, x_ff[COORD_W-2:0]};
         ry_in  = {1'b0, y_ff[COORD_W-2:0]};
         cx_in  = '0;
         cy_in  = '0;
         cnt_in = LVL_W'(LEVELS - 1);
      end
      if (ctl.div_step) begin
         rx_in = divx[COORD_W-1:0];
         ry_in = divy[COORD_W-1:0];
         cx_in = LEVELS'({cx_ff, divx[COORD_W]});
         cy_in = LEVELS'({cy_ff, divy[COORD_W]});
         if (flags.cnt_nz) begin
            cnt_in = cnt_ff - LVL_W'(1);
         end
      end
      if (ctl.fix) begin
         cx_in  = fine_cell(x_ff, dx, cx_ff);
         cy_in  = fine_cell(y_ff, dy, cy_ff);
         cnt_in = LVL_W'(LEVELS - 1);
      end
      if (ctl.lvl_step) begin
         cx_in    = cx_ff >> 1;
         cy_in    = cy_ff >> 1;
         cnt_in   = lvl_next;
         score_in = upd_score;
         if (upd_sat) begin
            status_in = 1'b1;
         end
      end
      if (ctl.clr_init) begin
         clr_addr_in = '0;
         score_in    = '0;
      end
      if (ctl.clr_step) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= EXTENT_W'(1);
         height_ff    <= EXTENT_W'(1);
         score_ff     <= '0;
         status_ff    <= 1'b0;
         cnt_ff       <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_ff <= csr_wdata;
            end else if (csr_index == CSR_IMAGE_HEIGHT) begin
               height_ff <= csr_wdata;
            end
         end
         score_ff     <= score_in;
         status_ff    <= status_in;
         cnt_ff       <= cnt_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= ctl.emit;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         x_ff    <= req_point_x;
         y_ff    <= req_point_y;
      end
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      if (ctl.rd_first || ctl.lvl_step) begin
         addr_ff <= rd_addr;
      end
      if (ctl.emit) begin
         rsp_score_ff  <= score_ff;
         rsp_status_ff <= status_ff;
      end
   end

   // Counter memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_count_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= cell_count_ff[rd_addr];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_score  = rsp_score_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

@@ src/vps_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module vps_seq
   import vps_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire seq_flags_type flags,
   output ctl_word_type       ctl,
   output logic               busy
);

   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic             take;

   // Program store: one control word per step.
   always_comb begin
      ctl = '0;
      case (upc_ff)
         STEP_IDLE: begin
            ctl.cond   = COND_NO_START;
            ctl.target = STEP_IDLE;
         end
         STEP_DISPATCH: begin
            ctl.cond   = COND_IS_CLEAR;
            ctl.target = STEP_CLR_INIT;
         end
         STEP_DIV_INIT: begin
            ctl.cond     = COND_IS_NOP;
            ctl.target   = STEP_DONE;
            ctl.div_init = 1'b1;
         end
         STEP_DIV_LOOP: begin
            ctl.cond     = COND_CNT_NZ;
            ctl.target   = STEP_DIV_LOOP;
            ctl.div_step = 1'b1;
         end
         STEP_FIX: begin
            ctl.fix = 1'b1;
         end
         STEP_RD_FIRST: begin
            ctl.rd_first = 1'b1;
         end
         STEP_LVL_LOOP: begin
            ctl.cond     = COND_CNT_NZ;
            ctl.target   = STEP_LVL_LOOP;
            ctl.lvl_step = 1'b1;
         end
         STEP_DONE: begin
            ctl.cond   = COND_ALWAYS;
            ctl.target = STEP_IDLE;
            ctl.emit   = 1'b1;
         end
         STEP_CLR_INIT: begin
            ctl.clr_init = 1'b1;
         end
         STEP_CLR_LOOP: begin
            ctl.cond     = COND_CLR_MORE;
            ctl.target   = STEP_CLR_LOOP;
            ctl.clr_step = 1'b1;
         end
         STEP_CLR_END: begin
            ctl.cond   = COND_ALWAYS;
            ctl.target = STEP_DONE;
         end
         STEP_RST_INIT: begin
            ctl.clr_init = 1'b1;
         end
         STEP_RST_LOOP: begin
            ctl.cond     = COND_CLR_MORE;
            ctl.target   = STEP_RST_LOOP;
            ctl.clr_step = 1'b1;
         end
         STEP_RST_END: begin
            ctl.cond   = COND_ALWAYS;
            ctl.target = STEP_IDLE;
         end
         default: begin
            ctl.cond   = COND_ALWAYS;
            ctl.target = STEP_IDLE;
         end
      endcase
   end

   always_comb begin
      case (ctl.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_START: take = !flags.start;
         COND_IS_CLEAR: take = flags.is_clear;
         COND_IS_NOP:   take = flags.is_nop;
         COND_CNT_NZ:   take = flags.cnt_nz;
         COND_CLR_MORE: take = flags.clr_more;
         default:       take = 1'b0;
      endcase
      upc_in = take ? ctl.target : upc_ff + UPC_W'(1);
   end

   assign busy = (upc_ff != STEP_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_RST_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

`default_nettype wire
